// ===== src/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, register indexes and constants of the spatial prediction
// filter.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MAX_ROW_BYTES_DEF = 16384;
  localparam int MAX_BPP_DEF       = 4;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int BPP_W      = 3;
  localparam int BPP_EFF_W  = 4;
  localparam int ROW_W      = 14;
  localparam int HEIGHT_MAX = 16384;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(HEIGHT_MAX - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_DIRECTION = 3'd1,
    CFG_BPP       = 3'd2,
    CFG_ROW_BYTES = 3'd3,
    CFG_HEIGHT    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_HORIZ    = 2'd1,
    MODE_VERT     = 2'd2,
    MODE_GRADIENT = 2'd3
  } mode_t;

  localparam logic DIR_FILTER   = 1'b0;
  localparam logic DIR_UNFILTER = 1'b1;

  typedef struct packed {
    mode_t                 mode;
    logic                  direction;
    logic [BPP_W-1:0]      bpp;
    logic [CFG_DATA_W-1:0] row_bytes;
    logic [CFG_DATA_W-1:0] image_height;
  } cfg_t;

  // position flags of one transaction
  typedef struct packed {
    logic first_row;
    logic first_pixel;
    logic eor;
    logic eoi;
  } pos_t;

endpackage

// ===== src/spf_line_store.sv =====
// ----------------------------------------------------------------------------
// spf_line_store
// Previous-row byte memory: one write and one registered read per cycle,
// with a bypass when the read hits the address written in the same cycle.
// ----------------------------------------------------------------------------
module spf_line_store #(
  parameter int DEPTH = spf_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [spf_pkg::BYTE_W-1:0] wr_data,
  output logic [spf_pkg::BYTE_W-1:0] rd_data
);

  logic [spf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [spf_pkg::BYTE_W-1:0] rd_r;
  logic [spf_pkg::BYTE_W-1:0] fwd_r;
  logic                       hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r  <= mem[rd_addr];
      fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = hit_r ? fwd_r : rd_r;

endmodule

// ===== src/spf_position.sv =====
// ----------------------------------------------------------------------------
// spf_position
// Column and row counters; flags the row and image position of each
// accepted transaction and wraps at the end of a row and of the image.
// ----------------------------------------------------------------------------
module spf_position #(
  parameter int MAX_ROW_BYTES = spf_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  spf_pkg::cfg_t                 cfg,
  input  logic [spf_pkg::BPP_EFF_W-1:0] bpp_eff,
  output logic [AW-1:0]                 col,
  output spf_pkg::pos_t                 pos
);

  localparam int CMPW = (AW + 1 > spf_pkg::CFG_DATA_W) ? AW + 1 : spf_pkg::CFG_DATA_W;
  localparam logic [AW-1:0] COL_LAST = AW'(MAX_ROW_BYTES - 1);

  logic [AW-1:0]             col_r;
  logic [AW-1:0]             col_nxt;
  logic [spf_pkg::ROW_W-1:0] row_r;
  logic [spf_pkg::ROW_W-1:0] row_nxt;
  logic [CMPW-1:0]           col_inc;
  logic [CMPW-1:0]           rb_eff;
  logic [spf_pkg::ROW_W:0]   row_inc;
  logic [spf_pkg::CFG_DATA_W-1:0] h_eff;

  always_comb begin
    rb_eff  = (cfg.row_bytes == '0) ? CMPW'(1) : CMPW'(cfg.row_bytes);
    h_eff   = (cfg.image_height == '0) ? spf_pkg::CFG_DATA_W'(1) : cfg.image_height;
    col_inc = CMPW'(col_r) + CMPW'(1);
    row_inc = {1'b0, row_r} + (spf_pkg::ROW_W + 1)'(1);

    pos.first_row   = (row_r == '0);
    pos.first_pixel = CMPW'(col_r) < CMPW'(bpp_eff);
    pos.eor         = (col_inc >= rb_eff) || (col_r == COL_LAST);
    pos.eoi         = pos.eor &&
                      ((spf_pkg::CFG_DATA_W'(row_inc) >= h_eff) ||
                       (row_r == spf_pkg::ROW_LAST));

    if (pos.eor) begin
      col_nxt = '0;
      row_nxt = pos.eoi ? '0 : row_inc[spf_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

endmodule

// ===== src/spf_datapath.sv =====
// ----------------------------------------------------------------------------
// spf_datapath
// Working stage: holds one transaction, forms the prediction from the left,
// up and up-left bytes, applies it and updates the left and up-left delay lines.
// ----------------------------------------------------------------------------
module spf_datapath #(
  parameter int MAX_BPP = spf_pkg::MAX_BPP_DEF,
  parameter int AW      = $clog2(spf_pkg::MAX_ROW_BYTES_DEF)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          advance,
  input  logic [spf_pkg::BYTE_W-1:0]    in_byte,
  input  logic [AW-1:0]                 in_col,
  input  spf_pkg::pos_t                 in_pos,
  input  logic [spf_pkg::BYTE_W-1:0]    up,
  input  spf_pkg::cfg_t                 cfg,
  input  logic [spf_pkg::BPP_EFF_W-1:0] bpp_eff,
  output logic [AW-1:0]                 wr_addr,
  output logic [spf_pkg::BYTE_W-1:0]    stored,
  output logic [spf_pkg::BYTE_W-1:0]    result,
  output spf_pkg::pos_t                 pos
);

  localparam int BIW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  logic [spf_pkg::BYTE_W-1:0] byte_r;
  logic [AW-1:0]              col_r;
  spf_pkg::pos_t              pos_r;
  logic [spf_pkg::BYTE_W-1:0] left_r [MAX_BPP];
  logic [spf_pkg::BYTE_W-1:0] ul_r   [MAX_BPP];

  logic [BIW-1:0]             sel;
  logic [spf_pkg::BYTE_W-1:0] left;
  logic [spf_pkg::BYTE_W-1:0] up_left;
  logic signed [9:0]          grad_sum;
  logic [spf_pkg::BYTE_W-1:0] grad;
  logic [spf_pkg::BYTE_W-1:0] pred;
  logic                       copy;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
      col_r  <= in_col;
      pos_r  <= in_pos;
    end
  end

  always_comb begin
    sel      = BIW'(bpp_eff - spf_pkg::BPP_EFF_W'(1));
    left     = left_r[sel];
    up_left  = ul_r[sel];
    grad_sum = $signed({2'b00, left}) + $signed({2'b00, up}) - $signed({2'b00, up_left});
    if (grad_sum[9]) begin
      grad = '0;
    end else if (grad_sum[8]) begin
      grad = 8'hFF;
    end else begin
      grad = grad_sum[7:0];
    end

    unique case (cfg.mode)
      spf_pkg::MODE_NONE: begin
        copy = 1'b1;
        pred = '0;
      end
      spf_pkg::MODE_HORIZ: begin
        copy = pos_r.first_pixel;
        pred = left;
      end
      spf_pkg::MODE_VERT: begin
        copy = pos_r.first_row;
        pred = up;
      end
      spf_pkg::MODE_GRADIENT: begin
        copy = pos_r.first_row || pos_r.first_pixel;
        pred = grad;
      end
      default: begin
        copy = 1'b1;
        pred = '0;
      end
    endcase

    if (copy) begin
      result = byte_r;
    end else if (cfg.direction == spf_pkg::DIR_UNFILTER) begin
      result = byte_r + pred;
    end else begin
      result = byte_r - pred;
    end

    stored = (cfg.direction == spf_pkg::DIR_UNFILTER) ? result : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        left_r[i] <= '0;
        ul_r[i]   <= '0;
      end
    end else if (advance) begin
      for (int i = 1; i < MAX_BPP; i++) begin
        if (spf_pkg::BPP_EFF_W'(i) < bpp_eff) begin
          left_r[i] <= left_r[i-1];
          ul_r[i]   <= ul_r[i-1];
        end
      end
      left_r[0] <= stored;
      ul_r[0]   <= up;
    end
  end

  assign wr_addr = col_r;
  assign pos     = pos_r;

endmodule

// ===== src/spatial_prediction_filter.sv =====
// ----------------------------------------------------------------------------
// spatial_prediction_filter
// Streaming spatial prediction filter / unfilter for 8-bit image planes.
//
// Input channel (in_valid / in_stall / in_byte) takes one byte per
// transaction in raster order; the result channel (out_valid / out_stall)
// returns one byte per input with end-of-row and end-of-image flags.
// Configuration is written through cfg_write_en / cfg_index / cfg_data and
// must only change while no transaction is in flight.
// An accepted byte passes from the working stage into the output register,
// whose valid bit drives out_valid. Throughput is one byte per cycle while
// out_stall does not hold the output, set by the single-port-per-side line
// store that is read at acceptance and written when the byte leaves the working
// stage. A write and a read of the same line-store entry in one cycle are
// bypassed. Reset clears the counters and the left/up-left delay lines and sets
// the configuration to its defaults; the line store is not cleared, so the first
// row after reset does not predict from it. When out_stall is held, the output
// register and the working stage fill and in_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module spatial_prediction_filter #(
  parameter int MAX_ROW_BYTES = spf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_BPP       = spf_pkg::MAX_BPP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spf_pkg::BYTE_W-1:0]     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spf_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_end_of_row,
  output logic                           out_end_of_image
);

  localparam int AW = $clog2(MAX_ROW_BYTES);

  spf_pkg::cfg_t                 cfg_r;
  logic [spf_pkg::BPP_EFF_W-1:0] bpp_eff;

  logic                          accept;
  logic                          s1_v_r;
  logic                          s1_adv;
  logic                          out_free;
  logic                          out_valid_r;
  logic [spf_pkg::BYTE_W-1:0]    out_byte_r;
  logic                          out_eor_r;
  logic                          out_eoi_r;

  logic [AW-1:0]                 col;
  spf_pkg::pos_t                 in_pos;
  logic [spf_pkg::BYTE_W-1:0]    up;
  logic [AW-1:0]                 wr_addr;
  logic [spf_pkg::BYTE_W-1:0]    stored;
  logic [spf_pkg::BYTE_W-1:0]    result;
  spf_pkg::pos_t                 s1_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= spf_pkg::MODE_NONE;
      cfg_r.direction    <= spf_pkg::DIR_FILTER;
      cfg_r.bpp          <= spf_pkg::BPP_W'(1);
      cfg_r.row_bytes    <= spf_pkg::CFG_DATA_W'(1);
      cfg_r.image_height <= spf_pkg::CFG_DATA_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        spf_pkg::CFG_MODE:      cfg_r.mode         <= spf_pkg::mode_t'(cfg_data[1:0]);
        spf_pkg::CFG_DIRECTION: cfg_r.direction    <= cfg_data[0];
        spf_pkg::CFG_BPP:       cfg_r.bpp          <= cfg_data[spf_pkg::BPP_W-1:0];
        spf_pkg::CFG_ROW_BYTES: cfg_r.row_bytes    <= cfg_data;
        spf_pkg::CFG_HEIGHT:    cfg_r.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_r.bpp == '0) begin
      bpp_eff = spf_pkg::BPP_EFF_W'(1);
    end else if ({1'b0, cfg_r.bpp} > spf_pkg::BPP_EFF_W'(MAX_BPP)) begin
      bpp_eff = spf_pkg::BPP_EFF_W'(MAX_BPP);
    end else begin
      bpp_eff = {1'b0, cfg_r.bpp};
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= result;
      out_eor_r  <= s1_pos.eor;
      out_eoi_r  <= s1_pos.eoi;
    end
  end

  spf_position #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .AW            (AW)
  ) u_position (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cfg     (cfg_r),
    .bpp_eff (bpp_eff),
    .col     (col),
    .pos     (in_pos)
  );

  spf_line_store #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_adv),
    .wr_addr (wr_addr),
    .wr_data (stored),
    .rd_data (up)
  );

  spf_datapath #(
    .MAX_BPP (MAX_BPP),
    .AW      (AW)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .advance (s1_adv),
    .in_byte (in_byte),
    .in_col  (col),
    .in_pos  (in_pos),
    .up      (up),
    .cfg     (cfg_r),
    .bpp_eff (bpp_eff),
    .wr_addr (wr_addr),
    .stored  (stored),
    .result  (result),
    .pos     (s1_pos)
  );

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;

  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("working stage advanced but no output transaction followed");

  a_eoi_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_end_of_image || out_end_of_row))
    else $error("end of image without end of row");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_pos.eor) |=> (col == '0))
    else $error("column counter did not wrap at end of row");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had room");

endmodule

// ===== bench/spatial_prediction_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_prediction_filter_tb
// Self-checking bench for the streaming spatial prediction filter. A short
// table of directed transactions and register writes is followed by random
// whole images, with random idling on both channels. Every accepted byte is
// run through a behavioral copy of the filter, and each result transaction is
// compared with the oldest pending expectation (the table's own result where it gives one).
// ----------------------------------------------------------------------------
module spatial_prediction_filter_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 680;

  typedef struct packed {
    logic [spf_pkg::BYTE_W-1:0] data;
    logic                       eor;
    logic                       eoi;
  } pixel_out_t;

  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    spf_pkg::cfg_idx_t              reg_idx;
    logic [spf_pkg::CFG_DATA_W-1:0] value;
    logic                           typed;
    pixel_out_t                     result;
  } plan_row_t;

  localparam pixel_out_t NO_RESULT = '0;

  localparam plan_row_t PLAN [37] = '{
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0A5, 1'b1, '{8'hA5, 1'b1, 1'b1}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h000, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0FF, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_WRITE, spf_pkg::CFG_MODE,      15'(spf_pkg::MODE_HORIZ),    1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_DIRECTION, 15'(spf_pkg::DIR_FILTER),    1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_BPP,       15'd1,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_ROW_BYTES, 15'd3,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_HEIGHT,    15'd2,   1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h010, 1'b1, '{8'h10, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h030, 1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h005, 1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0FF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h000, 1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h080, 1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_MODE,      15'(spf_pkg::MODE_GRADIENT), 1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_DIRECTION, 15'(spf_pkg::DIR_UNFILTER),  1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_ROW_BYTES, 15'd2,   1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h000, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0FF, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0FF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h001, 1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h0FF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h000, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h000, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h07F, 1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_MODE,      15'(spf_pkg::MODE_VERT),     1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_DIRECTION, 15'(spf_pkg::DIR_FILTER),    1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_BPP,       15'd0,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_ROW_BYTES, 15'd0,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_HEIGHT,    15'd0,   1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h03C, 1'b1, '{8'h3C, 1'b1, 1'b1}},
    '{ROW_WRITE, spf_pkg::CFG_MODE,      15'(spf_pkg::MODE_HORIZ),    1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_BPP,       15'd7,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_ROW_BYTES, 15'd2,   1'b0, NO_RESULT},
    '{ROW_WRITE, spf_pkg::CFG_HEIGHT,    15'd1,   1'b0, NO_RESULT},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h011, 1'b1, '{8'h11, 1'b0, 1'b0}},
    '{ROW_BYTE,  spf_pkg::CFG_MODE,      15'h022, 1'b1, '{8'h22, 1'b1, 1'b1}}
  };

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           cfg_write_en     = 1'b0;
  spf_pkg::cfg_idx_t              cfg_index        = spf_pkg::CFG_MODE;
  logic [spf_pkg::CFG_DATA_W-1:0] cfg_data         = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [spf_pkg::BYTE_W-1:0]     in_byte          = '0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic [spf_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_end_of_row;
  logic                           out_end_of_image;

  logic        quiet          = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  pixel_out_t  pending_bytes [$];
  pixel_out_t  want;

  // filter state and register shadow
  logic [spf_pkg::BYTE_W-1:0]     row_above   [spf_pkg::MAX_ROW_BYTES_DEF];
  logic [spf_pkg::BYTE_W-1:0]     left_line   [spf_pkg::MAX_BPP_DEF] = '{default: '0};
  logic [spf_pkg::BYTE_W-1:0]     upleft_line [spf_pkg::MAX_BPP_DEF] = '{default: '0};
  int unsigned                    col_pos       = 0;
  int unsigned                    row_pos       = 0;
  spf_pkg::mode_t                 cur_mode      = spf_pkg::MODE_NONE;
  logic                           cur_dir       = spf_pkg::DIR_FILTER;
  logic [spf_pkg::BPP_W-1:0]      cur_bpp       = 3'd1;
  logic [spf_pkg::CFG_DATA_W-1:0] cur_row_bytes = 15'd1;
  logic [spf_pkg::CFG_DATA_W-1:0] cur_height    = 15'd1;

  spatial_prediction_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_cfg(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    return raw > hi ? hi : raw;
  endfunction

  function automatic pixel_out_t filter_byte(logic [spf_pkg::BYTE_W-1:0] x);
    int unsigned                bpp, rb, h, idx;
    int                         grad, k;
    logic [spf_pkg::BYTE_W-1:0] up, left, upl, pred, stored;
    logic                       copy;
    pixel_out_t                 r;
    bpp  = clamp_cfg(int'(cur_bpp), spf_pkg::MAX_BPP_DEF);
    rb   = clamp_cfg(int'(cur_row_bytes), spf_pkg::MAX_ROW_BYTES_DEF);
    h    = clamp_cfg(int'(cur_height), spf_pkg::HEIGHT_MAX);
    idx  = col_pos < spf_pkg::MAX_ROW_BYTES_DEF ? col_pos : spf_pkg::MAX_ROW_BYTES_DEF - 1;
    up   = row_above[idx];
    left = left_line[bpp-1];
    upl  = upleft_line[bpp-1];
    grad = int'(left) + int'(up) - int'(upl);
    if (grad < 0) grad = 0;
    if (grad > 255) grad = 255;
    pred = '0;
    unique case (cur_mode)
      spf_pkg::MODE_HORIZ: begin
        copy = col_pos < bpp;
        pred = left;
      end
      spf_pkg::MODE_VERT: begin
        copy = row_pos == 0;
        pred = up;
      end
      spf_pkg::MODE_GRADIENT: begin
        copy = row_pos == 0 || col_pos < bpp;
        pred = spf_pkg::BYTE_W'(grad);
      end
      default: copy = 1'b1;
    endcase
    if (copy) r.data = x;
    else if (cur_dir == spf_pkg::DIR_UNFILTER) r.data = x + pred;
    else r.data = x - pred;
    stored = cur_dir == spf_pkg::DIR_UNFILTER ? r.data : x;
    for (k = int'(bpp) - 1; k > 0; k--) begin
      left_line[k]   = left_line[k-1];
      upleft_line[k] = upleft_line[k-1];
    end
    left_line[0]   = stored;
    upleft_line[0] = up;
    row_above[idx] = stored;
    r.eor = col_pos + 1 >= rb;
    r.eoi = r.eor && row_pos + 1 >= h;
    if (r.eor) begin
      col_pos = 0;
      row_pos = r.eoi ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  function automatic logic [spf_pkg::BYTE_W-1:0] random_pixel();
    unique case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return spf_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(spf_pkg::cfg_idx_t idx, logic [spf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    unique case (idx)
      spf_pkg::CFG_MODE:      cur_mode      = spf_pkg::mode_t'(val[1:0]);
      spf_pkg::CFG_DIRECTION: cur_dir       = val[0];
      spf_pkg::CFG_BPP:       cur_bpp       = val[spf_pkg::BPP_W-1:0];
      spf_pkg::CFG_ROW_BYTES: cur_row_bytes = val;
      spf_pkg::CFG_HEIGHT:    cur_height    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_byte(logic [spf_pkg::BYTE_W-1:0] b, logic typed,
                           pixel_out_t typed_result, output logic last);
    pixel_out_t p;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = filter_byte(b);
    pending_bytes.push_back(typed ? typed_result : p);
    last = p.eoi;
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !quiet && $urandom_range(99) < 6;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result transaction: out_byte %h", out_byte);
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          mismatch_count++;
        end
        if (out_end_of_row !== want.eor) begin
          $error("out_end_of_row: expected %b, got %b", want.eor, out_end_of_row);
          mismatch_count++;
        end
        if (out_end_of_image !== want.eoi) begin
          $error("out_end_of_image: expected %b, got %b", want.eoi, out_end_of_image);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** spatial_prediction_filter: FAILED **");
      $finish;
    end
  end

  initial begin
    logic        last, busy;
    int          phase, items, rows, cut, sent, images, done;
    int unsigned rb_eff;
    busy = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        send_byte(PLAN[i].value[spf_pkg::BYTE_W-1:0], PLAN[i].typed, PLAN[i].result, last);
        busy = 1'b1;
      end
    end

    // whole images with random content; bpp and row growth only at image start
    phase = 0;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      phase++;
      quiet = phase <= 3;
      settle();
      write_reg(spf_pkg::CFG_MODE, spf_pkg::CFG_DATA_W'($urandom));
      write_reg(spf_pkg::CFG_DIRECTION, spf_pkg::CFG_DATA_W'($urandom));
      write_reg(spf_pkg::CFG_BPP, spf_pkg::CFG_DATA_W'($urandom));
      if (phase == 3) begin
        // oversized row width, then a shrink that ends the row early
        write_reg(spf_pkg::CFG_ROW_BYTES, 15'h7FFF);
        write_reg(spf_pkg::CFG_HEIGHT, 15'd1);
        repeat (48) begin
          send_byte(random_pixel(), 1'b0, NO_RESULT, last);
          items++;
        end
        settle();
        write_reg(spf_pkg::CFG_ROW_BYTES, spf_pkg::CFG_DATA_W'($urandom_range(48, 1)));
        do begin
          send_byte(random_pixel(), 1'b0, NO_RESULT, last);
          items++;
        end while (!last);
      end else if (phase == 5) begin
        write_reg(spf_pkg::CFG_ROW_BYTES, spf_pkg::CFG_DATA_W'($urandom_range(4, 1)));
        write_reg(spf_pkg::CFG_HEIGHT, 15'h7FFF);
        rows = $urandom_range(8, 4) *
               clamp_cfg(int'(cur_row_bytes), spf_pkg::MAX_ROW_BYTES_DEF);
        repeat (rows) begin
          send_byte(random_pixel(), 1'b0, NO_RESULT, last);
          items++;
        end
        settle();
        write_reg(spf_pkg::CFG_HEIGHT, spf_pkg::CFG_DATA_W'($urandom_range(3)));
        do begin
          send_byte(random_pixel(), 1'b0, NO_RESULT, last);
          items++;
        end while (!last);
      end else begin
        write_reg(spf_pkg::CFG_ROW_BYTES, spf_pkg::CFG_DATA_W'($urandom_range(16)));
        write_reg(spf_pkg::CFG_HEIGHT, spf_pkg::CFG_DATA_W'($urandom_range(6)));
        rb_eff = clamp_cfg(int'(cur_row_bytes), spf_pkg::MAX_ROW_BYTES_DEF);
        images = $urandom_range(2, 1);
        cut    = $urandom_range(2) == 0 ?
                 $urandom_range(rb_eff * clamp_cfg(int'(cur_height), spf_pkg::HEIGHT_MAX), 1) :
                 0;
        sent = 0;
        done = 0;
        while (done < images) begin
          if (cut != 0 && sent == cut) begin
            // mid-image change: row width may only shrink
            settle();
            write_reg(spf_pkg::CFG_MODE, spf_pkg::CFG_DATA_W'($urandom));
            write_reg(spf_pkg::CFG_DIRECTION, spf_pkg::CFG_DATA_W'($urandom));
            write_reg(spf_pkg::CFG_ROW_BYTES, spf_pkg::CFG_DATA_W'($urandom_range(rb_eff)));
            write_reg(spf_pkg::CFG_HEIGHT, spf_pkg::CFG_DATA_W'($urandom_range(6)));
          end
          send_byte(random_pixel(), 1'b0, NO_RESULT, last);
          sent++;
          items++;
          if (last) done++;
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** spatial_prediction_filter: PASSED **");
    end else begin
      $display("** spatial_prediction_filter: FAILED **");
    end
    $finish;
  end

endmodule
